/* hdl/vap_pkg.sv */
package vap_pkg;

   localparam int RSP_DATA_W = 104;

   localparam logic [7:0] MAX_ADDR_RESET = 8'd50;
   localparam logic [10:0] POS_MAX = 11'd2047;
   localparam logic [3:0] TAIL_MAX = 4'd8;
   localparam logic [3:0] TYPE_ADVERT = 4'd1;
   localparam logic [3:0] VERSION_2 = 4'd2;
   localparam logic [3:0] VERSION_3 = 4'd3;
   localparam logic [7:0] AUTH_PASSWORD = 8'd1;

   localparam logic KIND_ADDRESS = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd3;

   localparam int FLAG_CAPPED = 0;
   localparam int FLAG_MISSING = 1;
   localparam int FLAG_PASSWORD = 2;
   localparam int FLAG_PASSWORD_CUT = 3;

   typedef struct packed {
      logic        kind;
      logic        last;
      logic [31:0] address_value;
      logic [1:0]  status;
      logic [3:0]  version;
      logic [7:0]  router_id;
      logic [7:0]  priority_res;
      logic [7:0]  addr_count;
      logic [7:0]  auth_kind;
      logic [11:0] interval;
      logic [15:0] checksum;
      logic [3:0]  note_flags;
   } result_type;

endpackage

/* hdl/vap_result_fifo.sv */
module vap_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  vap_pkg::result_type push0,
   input  vap_pkg::result_type push1,
   input  logic               pop,
   output vap_pkg::result_type head,
   output logic               not_empty,
   output logic               room_for_two
);
   import vap_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;
   localparam int CNT_W = 3;

   result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             pop_do;

   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CNT_W'(DEPTH - 2));
   assign pop_do       = pop & not_empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop_do);
         count_ff  <= count_ff + CNT_W'(push_count) - CNT_W'(pop_do);
      end
   end

endmodule

/* hdl/vrrp_advertisement_parser.sv */
// VRRP v2/v3 advertisement parser. Takes one IP payload byte per cycle on req_ (tlast on the
// final byte) and returns decoded virtual IPv4 addresses and one summary per packet on rsp_.
// Every byte is absorbed as soon as it is accepted; the byte that completes an address and also
// ends the packet yields two rsp_ transactions, which drain one at a time from a
// four-entry result queue. req_tready is low only while that queue cannot take two more
// results, so with rsp_tready held high a new byte is taken every cycle. The address cap
// on csr_ is always writable and should only change between packets.
module vrrp_advertisement_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [7:0]                      csr_data,    // max_addresses
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte
   input  logic                            req_tlast,   // end_of_packet
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // address_value, status, version, router_id, priority_res, addr_count,
   // auth_kind, interval, checksum, note_flags, 2 zero bits
   output logic [vap_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,   // result_kind
   output logic                            rsp_tlast    // last_result
);
   import vap_pkg::*;

   logic [7:0]  max_addr_ff;
   logic [10:0] pos_ff;
   logic [7:0]  hdr_ff [8];
   logic [31:0] shift_ff;
   logic [7:0]  done_ff;
   logic [3:0]  tail_ff;
   logic        rej_ff;

   logic        accept;
   logic [7:0]  hdr_cur [8];
   logic        pos_lt8;
   logic        first_bad;
   logic        rej_cur;
   logic [7:0]  limit;
   logic        take_addr;
   logic        emit_addr;
   logic [31:0] shift_in;
   logic [7:0]  done_in;
   logic [3:0]  tail_in;
   logic [10:0] pos_in;
   logic [3:0]  ver;
   logic        ver_bad;
   logic        type_bad;
   result_type  addr_res;
   result_type  sum_res;
   result_type  push0;
   result_type  push1;
   logic [1:0]  push_count;
   result_type  head;
   logic        room_for_two;

   assign csr_ready  = 1'b1;
   assign req_tready = room_for_two;
   assign accept     = req_tvalid & req_tready;
   assign pos_lt8    = (pos_ff[10:3] == 8'd0);

   always_comb begin
      hdr_cur = hdr_ff;
      if (pos_lt8) begin
         hdr_cur[pos_ff[2:0]] = req_tdata;
      end
   end

   assign first_bad = ((req_tdata[7:4] != VERSION_2) && (req_tdata[7:4] != VERSION_3))
                      || (req_tdata[3:0] != TYPE_ADVERT);
   assign rej_cur   = (pos_ff == 11'd0) ? first_bad : rej_ff;
   assign limit     = (hdr_ff[3] < max_addr_ff) ? hdr_ff[3] : max_addr_ff;
   assign take_addr = !pos_lt8 && !rej_ff && (done_ff < limit);
   assign emit_addr = take_addr && (pos_ff[1:0] == 2'd3);
   assign shift_in  = take_addr ? {shift_ff[23:0], req_tdata} : shift_ff;
   assign done_in   = emit_addr ? done_ff + 8'd1 : done_ff;
   assign tail_in   = (!pos_lt8 && !rej_ff && !take_addr && (tail_ff < TAIL_MAX))
                      ? tail_ff + 4'd1 : tail_ff;
   assign pos_in    = (pos_ff < POS_MAX) ? pos_ff + 11'd1 : pos_ff;

   assign ver      = hdr_cur[0][7:4];
   assign ver_bad  = (ver != VERSION_2) && (ver != VERSION_3);
   assign type_bad = (hdr_cur[0][3:0] != TYPE_ADVERT);

   always_comb begin
      addr_res               = '0;
      addr_res.kind          = KIND_ADDRESS;
      addr_res.last          = !req_tlast;
      addr_res.address_value = shift_in;
   end

   always_comb begin
      sum_res      = '0;
      sum_res.kind = KIND_SUMMARY;
      sum_res.last = 1'b1;
      if (pos_in[10:3] == 8'd0) begin
         sum_res.status = STATUS_SHORT;
      end else if (ver_bad) begin
         sum_res.status  = STATUS_BAD_VERSION;
         sum_res.version = ver;
      end else if (type_bad) begin
         sum_res.status  = STATUS_BAD_TYPE;
         sum_res.version = ver;
      end else begin
         sum_res.status       = STATUS_OK;
         sum_res.version      = ver;
         sum_res.router_id    = hdr_cur[1];
         sum_res.priority_res = hdr_cur[2];
         sum_res.addr_count   = hdr_cur[3];
         if (ver == VERSION_2) begin
            sum_res.auth_kind = hdr_cur[4];
            sum_res.interval  = {4'd0, hdr_cur[5]};
         end else begin
            sum_res.interval = {hdr_cur[4][3:0], hdr_cur[5]};
         end
         sum_res.checksum = {hdr_cur[6], hdr_cur[7]};
         if (hdr_cur[3] > max_addr_ff) begin
            sum_res.note_flags[FLAG_CAPPED] = 1'b1;
         end else if (done_in < hdr_cur[3]) begin
            sum_res.note_flags[FLAG_MISSING] = 1'b1;
         end
         if ((ver == VERSION_2) && (hdr_cur[4] == AUTH_PASSWORD)) begin
            if (tail_in >= TAIL_MAX) begin
               sum_res.note_flags[FLAG_PASSWORD] = 1'b1;
            end else begin
               sum_res.note_flags[FLAG_PASSWORD_CUT] = 1'b1;
            end
         end
      end
   end

   assign push0      = emit_addr ? addr_res : sum_res;
   assign push1      = sum_res;
   assign push_count = accept ? (2'(emit_addr) + 2'(req_tlast)) : 2'd0;

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff   <= hdr_cur;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff <= MAX_ADDR_RESET;
         pos_ff      <= '0;
         done_ff     <= '0;
         tail_ff     <= '0;
         rej_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_addr_ff <= csr_data;
         end
         if (accept) begin
            if (req_tlast) begin
               pos_ff  <= '0;
               done_ff <= '0;
               tail_ff <= '0;
               rej_ff  <= 1'b0;
            end else begin
               pos_ff  <= pos_in;
               done_ff <= done_in;
               tail_ff <= tail_in;
               rej_ff  <= rej_cur;
            end
         end
      end
   end

   vap_result_fifo u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (push0),
      .push1        (push1),
      .pop          (rsp_tready),
      .head         (head),
      .not_empty    (rsp_tvalid),
      .room_for_two (room_for_two)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {2'b00, head.note_flags, head.checksum, head.interval, head.auth_kind,
                       head.addr_count, head.priority_res, head.router_id, head.version,
                       head.status, head.address_value};

endmodule

/* hdl/vap_checker.sv */
module vap_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vap_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import vap_pkg::*;

   // queue is empty right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a summary always closes the results of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY) |-> rsp_tlast)
      else $error("summary without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ADDRESS) |-> (rsp_tdata[RSP_DATA_W-1:32] == '0))
      else $error("address result carries header fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("summary carries an address");

endmodule

bind vrrp_advertisement_parser vap_checker u_vap_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import vap_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 20;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   vrrp_advertisement_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser state as predicted
   logic [7:0]  hdr_bytes [8];
   logic [10:0] byte_pos;
   logic [31:0] addr_shift;
   logic [7:0]  addr_done;
   logic [3:0]  tail_count;
   logic        hdr_rejected;
   logic [7:0]  addr_cap;

   result_type  pending_results [$];
   logic [7:0]  pkt [$];
   int          fault_count;
   int          cycle_count;
   int          rsp_stall;
   int          bytes_sent;
   bit          steady_flow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL vrrp_advertisement_parser");
         $finish;
      end
   end

   function automatic void clear_packet_state();
      for (int i = 0; i < 8; i++) hdr_bytes[i] = 8'h00;
      byte_pos = '0;
      addr_shift = '0;
      addr_done = '0;
      tail_count = '0;
      hdr_rejected = 1'b0;
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic eop);
      result_type addr_r;
      result_type sum_r;
      bit         have_addr;
      logic [7:0] limit;
      logic [3:0] ver;
      logic [7:0] cnt;
      addr_r = '0;
      sum_r = '0;
      have_addr = 0;
      if (byte_pos < 11'd8) begin
         hdr_bytes[byte_pos[2:0]] = b;
         if (byte_pos == 11'd0) begin
            if ((b[7:4] != VERSION_2 && b[7:4] != VERSION_3) || b[3:0] != TYPE_ADVERT)
               hdr_rejected = 1'b1;
         end
      end else if (!hdr_rejected) begin
         limit = (hdr_bytes[3] < addr_cap) ? hdr_bytes[3] : addr_cap;
         if (addr_done < limit) begin
            addr_shift = {addr_shift[23:0], b};
            if (byte_pos[1:0] == 2'd3) begin
               addr_r.kind = KIND_ADDRESS;
               addr_r.address_value = addr_shift;
               addr_done = addr_done + 8'd1;
               have_addr = 1;
            end
         end else if (tail_count < TAIL_MAX) begin
            tail_count = tail_count + 4'd1;
         end
      end
      if (byte_pos < POS_MAX) byte_pos = byte_pos + 11'd1;

      if (eop) begin
         ver = hdr_bytes[0][7:4];
         cnt = hdr_bytes[3];
         sum_r.kind = KIND_SUMMARY;
         if (byte_pos < 11'd8) begin
            sum_r.status = STATUS_SHORT;
         end else if (ver != VERSION_2 && ver != VERSION_3) begin
            sum_r.status = STATUS_BAD_VERSION;
            sum_r.version = ver;
         end else if (hdr_bytes[0][3:0] != TYPE_ADVERT) begin
            sum_r.status = STATUS_BAD_TYPE;
            sum_r.version = ver;
         end else begin
            sum_r.status = STATUS_OK;
            sum_r.version = ver;
            sum_r.router_id = hdr_bytes[1];
            sum_r.priority_res = hdr_bytes[2];
            sum_r.addr_count = cnt;
            if (ver == VERSION_2) begin
               sum_r.auth_kind = hdr_bytes[4];
               sum_r.interval = {4'h0, hdr_bytes[5]};
            end else begin
               sum_r.interval = {hdr_bytes[4][3:0], hdr_bytes[5]};
            end
            sum_r.checksum = {hdr_bytes[6], hdr_bytes[7]};
            if (cnt > addr_cap) sum_r.note_flags[FLAG_CAPPED] = 1'b1;
            else if (addr_done < cnt) sum_r.note_flags[FLAG_MISSING] = 1'b1;
            if (ver == VERSION_2 && hdr_bytes[4] == AUTH_PASSWORD) begin
               if (tail_count >= TAIL_MAX) sum_r.note_flags[FLAG_PASSWORD] = 1'b1;
               else sum_r.note_flags[FLAG_PASSWORD_CUT] = 1'b1;
            end
         end
         sum_r.last = 1'b1;
         clear_packet_state();
      end else begin
         addr_r.last = 1'b1;
      end
      if (have_addr) pending_results.insert(pending_results.size(), addr_r);
      if (eop) pending_results.insert(pending_results.size(), sum_r);
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type act;
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.kind = rsp_tuser;
         act.last = rsp_tlast;
         {act.note_flags, act.checksum, act.interval, act.auth_kind, act.addr_count,
          act.priority_res, act.router_id, act.version, act.status,
          act.address_value} = rsp_tdata[101:0];
         if (pending_results.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected result transaction: %h kind %b", rsp_tdata, rsp_tuser);
            fault_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (act !== exp_r || rsp_tdata[103:102] !== 2'b00) begin
               if (fault_count < 10)
                  $display("result mismatch: expected %h actual %h pad %b",
                           exp_r, act, rsp_tdata[103:102]);
               fault_count++;
            end
         end
         rsp_stall = steady_flow ? 0 : $urandom_range(0, 5);
      end
   end

   // receiver back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_tready = 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic eop);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata = 8'($urandom_range(0, 255));
         req_tlast = 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = eop;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, eop);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_cap(logic [7:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      addr_cap = value;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data = 8'($urandom_range(0, 255));
   endtask

   function automatic void add_byte(logic [7:0] b);
      pkt.insert(pkt.size(), b);
   endfunction

   task automatic build_advert(logic [3:0] ver, logic [7:0] cnt, int n_addr,
                               logic [7:0] auth, int n_tail);
      pkt.delete();
      add_byte({ver, TYPE_ADVERT});
      add_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
         0: add_byte(8'h00);
         1: add_byte(8'hFF);
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
      add_byte(cnt);
      add_byte((ver == VERSION_2) ? auth : 8'($urandom_range(0, 255)));
      for (int i = 0; i < 3; i++) add_byte(8'($urandom_range(0, 255)));
      for (int i = 0; i < 4 * n_addr + n_tail; i++) add_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic test_short_packets();
      pkt = '{8'h21};
      send_packet();
      pkt = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_packet();
      pkt = '{8'h31, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
      send_packet();
   endtask

   task automatic test_bad_header();
      build_advert(4'h4, 8'd1, 1, 8'h00, 0);
      send_packet();
      build_advert(VERSION_2, 8'd1, 1, 8'h00, 0);
      pkt[0] = 8'h22;
      send_packet();
      build_advert(VERSION_3, 8'd0, 0, 8'h00, 0);
      pkt[0] = 8'hFF;
      send_packet();
      build_advert(VERSION_3, 8'd0, 0, 8'h00, 0);
      pkt[0] = 8'h30;
      send_packet();
   endtask

   task automatic test_v2_password();
      build_advert(VERSION_2, 8'd1, 1, AUTH_PASSWORD, 8);
      send_packet();
      build_advert(VERSION_2, 8'd1, 1, AUTH_PASSWORD, 3);
      send_packet();
      build_advert(VERSION_2, 8'd3, 1, 8'h00, 0);
      send_packet();
   endtask

   task automatic test_v3_fields();
      // address completes on the final byte: two results from one byte
      build_advert(VERSION_3, 8'd2, 2, 8'h00, 0);
      pkt[4] = 8'hFF;
      pkt[5] = 8'hFF;
      send_packet();
      build_advert(VERSION_3, 8'd0, 0, 8'h00, 2);
      pkt[4] = 8'h00;
      pkt[5] = 8'h00;
      send_packet();
   endtask

   task automatic test_cap_extremes();
      write_cap(8'd0);
      build_advert(VERSION_3, 8'd1, 1, 8'h00, 0);
      send_packet();
      write_cap(8'd255);
      build_advert(VERSION_2, 8'd255, 2, AUTH_PASSWORD, 0);
      send_packet();
      write_cap(8'd1);
      build_advert(VERSION_3, 8'd2, 2, 8'h00, 0);
      send_packet();
   endtask

   task automatic test_random_traffic();
      logic [7:0] caps [5];
      logic [3:0] ver;
      logic [7:0] cnt;
      int         phase;
      int         n_pkts;
      int         kind;
      int         cut;
      caps = '{8'd3, 8'd255, 8'd0, MAX_ADDR_RESET, 8'($urandom_range(0, 255))};
      phase = 0;
      n_pkts = 0;
      bytes_sent = 0;
      while (bytes_sent < 1500) begin
         if (bytes_sent >= 300 * (phase + 1) && phase < 4) begin
            phase++;
            write_cap(caps[phase]);
         end else if (n_pkts == 0) begin
            write_cap(caps[0]);
         end
         steady_flow = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            pkt.delete();
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
         end else begin
            ver = $urandom_range(0, 1) ? VERSION_2 : VERSION_3;
            cnt = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 6));
            build_advert(ver, cnt, $urandom_range(0, ((cnt < 6) ? cnt : 6) + 1),
                         $urandom_range(0, 1) ? AUTH_PASSWORD : 8'($urandom_range(0, 255)),
                         $urandom_range(0, 10));
            if (kind == 1) pkt[0] = 8'($urandom_range(0, 255));
            if (kind == 2) begin
               cut = $urandom_range(1, pkt.size());
               while (pkt.size() > cut) void'(pkt.pop_back());
            end
         end
         send_packet();
         n_pkts++;
         if (n_pkts % 10 == 0) wait_drained();
      end
      steady_flow = 0;
   endtask

   task automatic test_long_packet();
      write_cap(8'd255);
      steady_flow = 1;
      build_advert(VERSION_3, 8'd255, 255, 8'h00, 1100);
      send_packet();
      steady_flow = 0;
      write_cap(MAX_ADDR_RESET);
      build_advert(VERSION_2, 8'd2, 2, AUTH_PASSWORD, 9);
      send_packet();
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = 8'h00;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      fault_count = 0;
      rsp_stall = 0;
      bytes_sent = 0;
      steady_flow = 0;
      addr_cap = MAX_ADDR_RESET;
      clear_packet_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_packets();
      test_bad_header();
      test_v2_password();
      test_v3_fields();
      test_cap_extremes();
      test_random_traffic();
      test_long_packet();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("PASS vrrp_advertisement_parser");
      end else begin
         $display("FAIL vrrp_advertisement_parser");
      end
      $finish;
   end

endmodule
